// File: hw/rtl/chs_pkg.sv
// Shared types and constants for the chained hash set.
package chs_pkg;

  localparam int unsigned OUT_COUNT_W = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic                   hit;
    logic [OUT_COUNT_W-1:0] count;
    logic                   is_empty;
    logic                   overflow;
  } out_word_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_LOOK
  } back_state_t;

endpackage

// File: hw/rtl/chs_front.sv
// Front end: accepts request words, normalizes the key and computes its bucket.
module chs_front #(
  parameter int unsigned NUM_BUCKETS = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned BKT_W       = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  chs_pkg::in_word_t   in_word,
  output logic                push_valid,
  input  logic                push_ready,
  output chs_pkg::op_t        push_op,
  output logic [KEY_BITS-1:0] push_key,
  output logic [BKT_W-1:0]    push_bucket
);

  localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

  logic [63:0]         key_ext;
  logic [KEY_BITS-1:0] nkey;

  assign key_ext = {{32{in_word.key[31]}}, in_word.key};
  assign nkey    = key_ext[KEY_BITS-1:0];

  if (IS_POW2) begin : g_pow2
    logic [KEY_BITS-1:0] bmask;

    assign bmask       = KEY_BITS'(NUM_BUCKETS - 1);
    assign push_valid  = in_valid;
    assign in_stall    = !push_ready;
    assign push_op     = in_word.op;
    assign push_key    = nkey;
    assign push_bucket = BKT_W'(nkey & bmask);
  end else begin : g_serial
    localparam int unsigned DIG   = 4;
    localparam int unsigned PADW  = ((KEY_BITS + DIG - 1) / DIG) * DIG;
    localparam int unsigned NSTEP = PADW / DIG;
    localparam int unsigned CNT_W = $clog2(NSTEP + 1);
    localparam int unsigned RW    = BKT_W + 1;

    chs_pkg::front_state_t state_r, state_nxt;
    chs_pkg::op_t          op_r;
    logic [KEY_BITS-1:0]   key_r;
    logic [PADW-1:0]       shift_r;
    logic [BKT_W-1:0]      rem_r, rem_nxt;
    logic [CNT_W-1:0]      cnt_r;
    logic                  accept;
    logic [RW-1:0]         r_tmp;

    assign accept = in_valid && (state_r == chs_pkg::F_IDLE);

    always_comb begin
      r_tmp = {1'b0, rem_r};
      for (int i = 0; i < DIG; i++) begin
        r_tmp = {r_tmp[RW-2:0], shift_r[PADW-1-i]};
        if (r_tmp >= RW'(NUM_BUCKETS)) begin
          r_tmp = r_tmp - RW'(NUM_BUCKETS);
        end
      end
      rem_nxt = r_tmp[BKT_W-1:0];
    end

    always_comb begin
      state_nxt  = state_r;
      in_stall   = 1'b1;
      push_valid = 1'b0;
      case (state_r)
        chs_pkg::F_IDLE: begin
          in_stall = 1'b0;
          if (in_valid) state_nxt = chs_pkg::F_MOD;
        end
        chs_pkg::F_MOD: begin
          if (cnt_r == CNT_W'(1)) state_nxt = chs_pkg::F_PUSH;
        end
        chs_pkg::F_PUSH: begin
          push_valid = 1'b1;
          if (push_ready) state_nxt = chs_pkg::F_IDLE;
        end
        default: state_nxt = chs_pkg::F_IDLE;
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        state_r <= chs_pkg::F_IDLE;
      end else begin
        state_r <= state_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        op_r    <= in_word.op;
        key_r   <= nkey;
        shift_r <= PADW'(nkey);
        rem_r   <= '0;
        cnt_r   <= CNT_W'(NSTEP);
      end else if (state_r == chs_pkg::F_MOD) begin
        rem_r   <= rem_nxt;
        shift_r <= shift_r << DIG;
        cnt_r   <= cnt_r - CNT_W'(1);
      end
    end

    assign push_op     = op_r;
    assign push_key    = key_r;
    assign push_bucket = rem_r;
  end

endmodule

// File: hw/rtl/chs_queue.sv
// Two-entry queue between the front end and the back end.
module chs_queue #(
  parameter int unsigned WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       fill_r;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: hw/rtl/chs_back.sv
// Back end: reads a bucket row, compares its slots, writes back and builds the result word.
module chs_back #(
  parameter int unsigned NUM_BUCKETS  = 64,
  parameter int unsigned BUCKET_SLOTS = 4,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned BKT_W        = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  chs_pkg::op_t         q_op,
  input  logic [KEY_BITS-1:0]  q_key,
  input  logic [BKT_W-1:0]     q_bucket,
  output logic                 out_valid,
  input  logic                 out_stall,
  output chs_pkg::out_word_t   out_word
);

  localparam int unsigned ROW_W = BUCKET_SLOTS * KEY_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_BUCKETS * BUCKET_SLOTS + 1);

  logic [ROW_W-1:0]        mem [NUM_BUCKETS];
  logic [BUCKET_SLOTS-1:0] valid_r [NUM_BUCKETS];

  chs_pkg::back_state_t state_r, state_nxt;
  chs_pkg::op_t         op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [BKT_W-1:0]     row_r;
  logic [ROW_W-1:0]     rd_data_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  chs_pkg::out_word_t   out_word_r, out_word_nxt;

  logic [BUCKET_SLOTS-1:0] vbits, match, free_mask, match_oh, free_oh;
  logic [ROW_W-1:0]        new_row;
  logic                    hit, out_free, finish;
  logic                    mem_we, set_valid, drop_valid, clear_all;

  assign vbits     = valid_r[row_r];
  assign free_mask = ~vbits;
  assign match_oh  = match & (~match + BUCKET_SLOTS'(1));
  assign free_oh   = free_mask & (~free_mask + BUCKET_SLOTS'(1));
  assign hit       = |match;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      match[s] = vbits[s] && (rd_data_r[s*KEY_BITS +: KEY_BITS] == key_r);
      new_row[s*KEY_BITS +: KEY_BITS] = free_oh[s] ? key_r
                                                   : rd_data_r[s*KEY_BITS +: KEY_BITS];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    finish       = 1'b0;
    mem_we       = 1'b0;
    set_valid    = 1'b0;
    drop_valid   = 1'b0;
    clear_all    = 1'b0;
    count_nxt    = count_r;
    out_word_nxt = out_word_r;
    case (state_r)
      chs_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = chs_pkg::B_LOOK;
        end
      end
      chs_pkg::B_LOOK: begin
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = chs_pkg::B_IDLE;
          out_word_nxt.hit      = hit;
          out_word_nxt.overflow = 1'b0;
          case (op_r)
            chs_pkg::OP_CLEAR: begin
              clear_all            = 1'b1;
              count_nxt            = '0;
              out_word_nxt.hit     = 1'b0;
            end
            chs_pkg::OP_INSERT: begin
              if (!hit) begin
                if (|free_mask) begin
                  mem_we    = 1'b1;
                  set_valid = 1'b1;
                  count_nxt = count_r + CNT_W'(1);
                end else begin
                  out_word_nxt.overflow = 1'b1;
                end
              end
            end
            chs_pkg::OP_ERASE: begin
              if (hit) begin
                drop_valid = 1'b1;
                count_nxt  = count_r - CNT_W'(1);
              end
            end
            default: ;
          endcase
          out_word_nxt.count    = chs_pkg::OUT_COUNT_W'(count_nxt);
          out_word_nxt.is_empty = (count_nxt == '0);
        end
      end
      default: state_nxt = chs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chs_pkg::B_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      for (int b = 0; b < NUM_BUCKETS; b++) valid_r[b] <= '0;
    end else if (set_valid) begin
      valid_r[row_r] <= vbits | free_oh;
    end else if (drop_valid) begin
      valid_r[row_r] <= vbits & ~match_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[row_r] <= new_row;
    if (q_pop) begin
      rd_data_r <= mem[q_bucket];
      op_r      <= q_op;
      key_r     <= q_key;
      row_r     <= q_bucket;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: hw/rtl/chained_hash_set_core.sv
// Top level of the chained hash set: front end, request queue and bucket engine.
// A set of signed keys in NUM_BUCKETS buckets of BUCKET_SLOTS slots; each request
// word (insert, erase, find, clear) returns one result word with hit, count,
// is_empty and overflow. For each request the bucket engine first reads the bucket row
// from the key memory, then compares all slots at once and writes back.
// With a power-of-two NUM_BUCKETS the bucket is the key's low bits and the
// front end is combinational; otherwise the front end reduces the key modulo
// NUM_BUCKETS four bits per cycle and takes no new request until it has pushed
// the last one. A two-entry queue and an output register decouple the sides.
// Slot valid bits are flip-flops cleared at once by reset and by clear, so no
// clearing pass is needed after reset.
module chained_hash_set_core #(
  parameter int unsigned NUM_BUCKETS  = 64,
  parameter int unsigned BUCKET_SLOTS = 4,
  parameter int unsigned KEY_BITS     = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  chs_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output chs_pkg::out_word_t  out_word
);

  localparam int unsigned BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned Q_W   = 2 + KEY_BITS + BKT_W;

  logic                push_valid, push_ready;
  chs_pkg::op_t        push_op;
  logic [KEY_BITS-1:0] push_key;
  logic [BKT_W-1:0]    push_bucket;
  logic                q_valid, q_pop;
  logic [Q_W-1:0]      q_data;

  chs_front #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KEY_BITS    (KEY_BITS),
    .BKT_W       (BKT_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_op     (push_op),
    .push_key    (push_key),
    .push_bucket (push_bucket)
  );

  chs_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_op, push_key, push_bucket}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  chs_back #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .KEY_BITS     (KEY_BITS),
    .BKT_W        (BKT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_op      (chs_pkg::op_t'(q_data[Q_W-1 -: 2])),
    .q_key     (q_data[BKT_W +: KEY_BITS]),
    .q_bucket  (q_data[BKT_W-1:0]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// File: sim/chained_hash_set_core_tb.sv
// Testbench for chained_hash_set_core: directed and random requests checked against a set model.
module chained_hash_set_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BUCKETS  = 64;
  localparam int BUCKET_SLOTS = 4;
  localparam int SLOT_TOTAL   = NUM_BUCKETS * BUCKET_SLOTS;
  localparam int POOL_SIZE    = 24;
  localparam int DIR_ROWS     = 24;
  localparam int PHASE_ITEMS  = 40;
  localparam int HOLD_OFF     = 80;

  typedef struct {
    chs_pkg::op_t       op;
    logic [31:0]        key;
    bit                 typed;
    chs_pkg::out_word_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  chs_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  chs_pkg::out_word_t out_word;

  logic [31:0] set_keys [SLOT_TOTAL];
  bit          set_valid [SLOT_TOTAL];
  int unsigned set_size;

  chs_pkg::out_word_t pending_results [$];
  logic [31:0]        key_pool [POOL_SIZE];
  dir_row_t           dir_rows [DIR_ROWS];
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_request = 0;
  int                 fail_count = 0;

  chained_hash_set_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic chs_pkg::out_word_t res(bit hit, int unsigned count, bit is_empty,
                                             bit overflow);
    chs_pkg::out_word_t r;
    r.hit      = hit;
    r.count    = count[chs_pkg::OUT_COUNT_W-1:0];
    r.is_empty = is_empty;
    r.overflow = overflow;
    return r;
  endfunction

  function automatic chs_pkg::out_word_t predict_set_op(chs_pkg::in_word_t w);
    logic [31:0]        k;
    int                 base;
    int                 hit_slot;
    int                 free_slot;
    chs_pkg::out_word_t r;
    k         = w.key;
    base      = int'(k % NUM_BUCKETS) * BUCKET_SLOTS;
    hit_slot  = -1;
    free_slot = -1;
    r         = '0;
    if (w.op == chs_pkg::OP_CLEAR) begin
      foreach (set_valid[i]) set_valid[i] = 1'b0;
      set_size = 0;
    end else begin
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
        if (set_valid[base + s]) begin
          if (hit_slot < 0 && set_keys[base + s] == k) hit_slot = s;
        end else if (free_slot < 0) begin
          free_slot = s;
        end
      end
      r.hit = (hit_slot >= 0);
      if (w.op == chs_pkg::OP_INSERT && !r.hit) begin
        if (free_slot >= 0) begin
          set_keys[base + free_slot]  = k;
          set_valid[base + free_slot] = 1'b1;
          set_size++;
        end else begin
          r.overflow = 1'b1;
        end
      end else if (w.op == chs_pkg::OP_ERASE && r.hit) begin
        set_valid[base + hit_slot] = 1'b0;
        set_size--;
      end
    end
    r.count    = set_size[chs_pkg::OUT_COUNT_W-1:0];
    r.is_empty = (set_size == 0);
    return r;
  endfunction

  task automatic send_word(chs_pkg::in_word_t w, bit typed, chs_pkg::out_word_t want);
    chs_pkg::out_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    predicted = predict_set_op(w);
    pending_results = {pending_results, (typed ? want : predicted)};
  endtask

  task automatic send_random;
    chs_pkg::in_word_t w;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 45) w.op = chs_pkg::OP_INSERT;
    else if (pick < 70) w.op = chs_pkg::OP_ERASE;
    else if (pick < 97) w.op = chs_pkg::OP_FIND;
    else w.op = chs_pkg::OP_CLEAR;
    w.key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
    send_word(w, 1'b0, '0);
  endtask

  // clear the set, fill every slot, then push six more keys into full buckets
  task automatic fill_store;
    chs_pkg::in_word_t w;
    logic [31:0]       rnd;
    w.op  = chs_pkg::OP_CLEAR;
    w.key = $urandom;
    send_word(w, 1'b0, '0);
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
        rnd   = $urandom;
        w.op  = chs_pkg::OP_INSERT;
        w.key = {rnd[31:6], 6'(b)};
        send_word(w, 1'b0, '0);
      end
    end
    for (int i = 0; i < 6; i++) begin
      w.op  = chs_pkg::OP_INSERT;
      w.key = $urandom;
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    int hold_left;
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    chs_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: actual %p", $realtime, out_word);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, out_word.hit);
        check_field("count", want.count, out_word.count);
        check_field("is_empty", want.is_empty, out_word.is_empty);
        check_field("overflow", want.overflow, out_word.overflow);
      end
    end
  end

  initial begin
    #200000ns;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    chs_pkg::in_word_t w;
    logic [31:0]       rnd;
    foreach (set_valid[i]) begin
      set_valid[i] = 1'b0;
      set_keys[i]  = '0;
    end
    set_size = 0;
    foreach (key_pool[i]) begin
      rnd         = $urandom;
      key_pool[i] = {rnd[31:6], 6'($urandom_range(5))};
    end
    dir_rows = '{
      '{chs_pkg::OP_FIND,   32'h0000_0000, 1'b1, res(0, 0, 1, 0)},
      '{chs_pkg::OP_ERASE,  32'h0000_0005, 1'b1, res(0, 0, 1, 0)},
      '{chs_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, res(0, 1, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'h8000_0000, 1'b1, res(0, 2, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, res(0, 3, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, res(1, 3, 0, 0)},
      '{chs_pkg::OP_FIND,   32'hFFFF_FFFF, 1'b1, res(1, 3, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'h0000_0040, 1'b1, res(0, 4, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'h0000_0080, 1'b1, res(0, 5, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'h0000_00C0, 1'b1, res(0, 6, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'h0000_0100, 1'b1, res(0, 6, 0, 1)},
      '{chs_pkg::OP_ERASE,  32'h0000_0040, 1'b1, res(1, 5, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'h0000_0100, 1'b1, res(0, 6, 0, 0)},
      '{chs_pkg::OP_FIND,   32'h0000_0040, 1'b1, res(0, 6, 0, 0)},
      '{chs_pkg::OP_FIND,   32'h0000_0100, 1'b1, res(1, 6, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'h0000_0000, 1'b1, res(0, 6, 0, 1)},
      '{chs_pkg::OP_ERASE,  32'h8000_0000, 1'b1, res(1, 5, 0, 0)},
      '{chs_pkg::OP_INSERT, 32'h0000_0000, 1'b1, res(0, 6, 0, 0)},
      '{chs_pkg::OP_FIND,   32'h7FFF_FFC0, 1'b0, res(0, 0, 0, 0)},
      '{chs_pkg::OP_CLEAR,  32'h0000_0000, 1'b1, res(0, 0, 1, 0)},
      '{chs_pkg::OP_CLEAR,  32'h5555_5555, 1'b1, res(0, 0, 1, 0)},
      '{chs_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b1, res(0, 1, 0, 0)},
      '{chs_pkg::OP_FIND,   32'hAAAA_AAAA, 1'b0, res(0, 0, 0, 0)},
      '{chs_pkg::OP_ERASE,  32'hAAAA_AAAA, 1'b1, res(1, 0, 1, 0)}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      w.op  = dir_rows[i].op;
      w.key = dir_rows[i].key;
      send_word(w, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 56;
          stall_pct     = 0;
          hold_request  = HOLD_OFF;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 56;
          fill_store();
        end
        default: begin
          send_idle_pct = 11;
          stall_pct     = 11;
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: chained_hash_set_core.f
hw/rtl/chs_pkg.sv
hw/rtl/chs_front.sv
hw/rtl/chs_queue.sv
hw/rtl/chs_back.sv
hw/rtl/chained_hash_set_core.sv
sim/chained_hash_set_core_tb.sv
